/* rtl/sita_pkg.sv */
// shared opcodes, status codes, state type and control structs for the idle-time table
`default_nettype none

package sita_pkg;

    localparam logic [2:0] OP_CLAIM     = 3'd0;
    localparam logic [2:0] OP_RELEASE   = 3'd1;
    localparam logic [2:0] OP_MARK_IDLE = 3'd2;
    localparam logic [2:0] OP_MARK_BUSY = 3'd3;
    localparam logic [2:0] OP_SNAPSHOT  = 3'd4;

    localparam logic [2:0] ST_OK          = 3'd0;
    localparam logic [2:0] ST_FULL        = 3'd1;
    localparam logic [2:0] ST_NOT_CLAIMED = 3'd2;
    localparam logic [2:0] ST_ZERO_TIME   = 3'd3;
    localparam logic [2:0] ST_EMPTY       = 3'd4;

    typedef enum logic [1:0] {
        S_IDLE,
        S_WALK,
        S_SPAN,
        S_APPLY
    } state_t;

    typedef struct packed {
        logic load_item;
        logic issue;
    } ctrl_cmd_t;

    typedef struct packed {
        logic issue_last;
    } dp_status_t;

endpackage

`default_nettype wire

/* rtl/sita_ctrl.sv */
// controller state machine: accepts a transaction, walks snapshot reads, drains the datapath
`default_nettype none

module sita_ctrl (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 start,
    output logic                      busy,
    input  wire sita_pkg::dp_status_t dp_status,
    output sita_pkg::ctrl_cmd_t       cmd
);

    sita_pkg::state_t state_reg;
    sita_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= sita_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            sita_pkg::S_IDLE:
            begin
                if (start)
                begin
                    state_next = dp_status.issue_last ? sita_pkg::S_SPAN : sita_pkg::S_WALK;
                end
            end
            sita_pkg::S_WALK:
            begin
                if (dp_status.issue_last)
                begin
                    state_next = sita_pkg::S_SPAN;
                end
            end
            sita_pkg::S_SPAN:
            begin
                state_next = sita_pkg::S_APPLY;
            end
            sita_pkg::S_APPLY:
            begin
                state_next = sita_pkg::S_IDLE;
            end
            default:
            begin
                state_next = sita_pkg::S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        busy          = (state_reg != sita_pkg::S_IDLE);
        cmd.load_item = (state_reg == sita_pkg::S_IDLE) && start;
        cmd.issue     = cmd.load_item || (state_reg == sita_pkg::S_WALK);
    end

endmodule

`default_nettype wire

/* rtl/sita_datapath.sv */
// datapath: slot flags, slot memories, three-stage read / span / apply pipe and result register
`default_nettype none

module sita_datapath #(
    parameter int SLOT_COUNT = 32
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire sita_pkg::ctrl_cmd_t cmd,
    output sita_pkg::dp_status_t     dp_status,
    input  wire logic [2:0]          op,
    input  wire logic [4:0]          slot,
    input  wire logic [63:0]         now,
    input  wire logic [55:0]         name_tag,
    output logic                     done,
    output logic [2:0]               status,
    output logic [4:0]               slot_index,
    output logic [63:0]              idle_total,
    output logic [63:0]              claimed_at,
    output logic [55:0]              slot_name,
    output logic                     last
);

    localparam int         DEPTH      = (SLOT_COUNT < 32) ? SLOT_COUNT : 32;
    localparam int         IDX_W      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam logic [5:0] SLOT_LIMIT = 6'(DEPTH);

    // per-slot flags
    logic [DEPTH-1:0] in_use_reg;
    logic [DEPTH-1:0] in_use_next;
    logic [DEPTH-1:0] is_idle_reg;
    logic [DEPTH-1:0] is_idle_next;

    // slot memories
    logic [63:0] idle_start_mem [DEPTH];
    logic [63:0] idle_sum_mem   [DEPTH];
    logic [63:0] claim_time_mem [DEPTH];
    logic [55:0] name_mem       [DEPTH];

    // transaction fields
    logic [2:0]  op_reg;
    logic [4:0]  slot_reg;
    logic [63:0] now_reg;
    logic [55:0] tag_reg;

    // read stage
    logic [2:0]       op_sel;
    logic [DEPTH-1:0] above_cur;
    logic [DEPTH-1:0] search_vec;
    logic [DEPTH-1:0] above_sel;
    logic [DEPTH-1:0] rest_vec;
    logic [IDX_W-1:0] sel_idx;
    logic [IDX_W-1:0] rd_idx;
    logic             sel_found;
    logic             sel_last;

    logic             p1_valid_reg;
    logic [IDX_W-1:0] p1_idx_reg;
    logic             p1_last_reg;
    logic             p1_found_reg;
    logic             p1_inuse_reg;
    logic             p1_idle_reg;
    logic [63:0]      rd_start_reg;
    logic [63:0]      rd_sum_reg;
    logic [63:0]      rd_claim_reg;
    logic [55:0]      rd_name_reg;

    // span stage
    logic [63:0]      span_diff;
    logic [63:0]      span;

    logic             p2_valid_reg;
    logic [IDX_W-1:0] p2_idx_reg;
    logic             p2_last_reg;
    logic             p2_found_reg;
    logic             p2_inuse_reg;
    logic             p2_idle_reg;
    logic [63:0]      p2_span_reg;
    logic [63:0]      p2_sum_reg;
    logic [63:0]      p2_claim_reg;
    logic [55:0]      p2_name_reg;

    // apply stage
    logic        in_range;
    logic [63:0] total_sum;
    logic        res_emit;
    logic [2:0]  res_status;
    logic [4:0]  res_idx;
    logic [63:0] res_total;
    logic [63:0] res_claim;
    logic [55:0] res_name;
    logic        res_last;
    logic        wr_start_en;
    logic        wr_sum_en;
    logic [63:0] wr_sum_data;
    logic        wr_claim_en;

    // result register
    logic        done_reg;
    logic [2:0]  status_reg;
    logic [4:0]  slot_index_reg;
    logic [63:0] idle_total_reg;
    logic [63:0] claimed_at_reg;
    logic [55:0] slot_name_reg;
    logic        last_reg;

    // slot selection: free slot for claim, next claimed slot for snapshot, the addressed slot otherwise
    always_comb
    begin
        op_sel = cmd.load_item ? op : op_reg;
        for (int k = 0; k < DEPTH; k++)
        begin
            above_cur[k] = (IDX_W'(k) > p1_idx_reg);
        end
        if (op_sel == sita_pkg::OP_CLAIM)
        begin
            search_vec = ~in_use_reg;
        end
        else if (!cmd.load_item)
        begin
            search_vec = in_use_reg & above_cur;
        end
        else
        begin
            search_vec = in_use_reg;
        end
        sel_found = |search_vec;
        sel_idx   = '0;
        for (int k = DEPTH - 1; k >= 0; k--)
        begin
            if (search_vec[k])
            begin
                sel_idx = IDX_W'(k);
            end
        end
        for (int k = 0; k < DEPTH; k++)
        begin
            above_sel[k] = (IDX_W'(k) > sel_idx);
        end
        rest_vec = search_vec & above_sel;
        rd_idx   = sel_idx;
        sel_last = 1'b1;
        if (op_sel == sita_pkg::OP_SNAPSHOT)
        begin
            sel_last = ~|rest_vec;
        end
        else if (op_sel != sita_pkg::OP_CLAIM)
        begin
            rd_idx = slot[IDX_W-1:0];
        end
        dp_status.issue_last = sel_last;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p1_valid_reg <= 1'b0;
            p2_valid_reg <= 1'b0;
            done_reg     <= 1'b0;
            in_use_reg   <= '0;
            is_idle_reg  <= '0;
        end
        else
        begin
            p1_valid_reg <= cmd.issue;
            p2_valid_reg <= p1_valid_reg;
            done_reg     <= res_emit;
            in_use_reg   <= in_use_next;
            is_idle_reg  <= is_idle_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
        begin
            op_reg   <= op;
            slot_reg <= slot;
            now_reg  <= now;
            tag_reg  <= name_tag;
        end
        if (cmd.issue)
        begin
            p1_idx_reg   <= rd_idx;
            p1_last_reg  <= sel_last;
            p1_found_reg <= sel_found;
            p1_inuse_reg <= in_use_reg[rd_idx];
            p1_idle_reg  <= is_idle_reg[rd_idx];
            rd_start_reg <= idle_start_mem[rd_idx];
            rd_sum_reg   <= idle_sum_mem[rd_idx];
            rd_claim_reg <= claim_time_mem[rd_idx];
            rd_name_reg  <= name_mem[rd_idx];
        end
    end

    // open span, zero when the slot is not idle or time went backwards
    always_comb
    begin
        span_diff = now_reg - rd_start_reg;
        span      = (p1_idle_reg && (now_reg > rd_start_reg)) ? span_diff : '0;
    end

    always_ff @(posedge clk)
    begin
        p2_idx_reg   <= p1_idx_reg;
        p2_last_reg  <= p1_last_reg;
        p2_found_reg <= p1_found_reg;
        p2_inuse_reg <= p1_inuse_reg;
        p2_idle_reg  <= p1_idle_reg;
        p2_span_reg  <= span;
        p2_sum_reg   <= rd_sum_reg;
        p2_claim_reg <= rd_claim_reg;
        p2_name_reg  <= rd_name_reg;
    end

    always_comb
    begin
        in_range     = ({1'b0, slot_reg} < SLOT_LIMIT);
        total_sum    = p2_sum_reg + p2_span_reg;
        in_use_next  = in_use_reg;
        is_idle_next = is_idle_reg;
        res_emit     = 1'b0;
        res_status   = sita_pkg::ST_OK;
        res_idx      = slot_reg;
        res_total    = '0;
        res_claim    = '0;
        res_name     = '0;
        res_last     = 1'b1;
        wr_start_en  = 1'b0;
        wr_sum_en    = 1'b0;
        wr_sum_data  = total_sum;
        wr_claim_en  = 1'b0;
        if (p2_valid_reg)
        begin
            case (op_reg) inside
                sita_pkg::OP_CLAIM:
                begin
                    res_emit = 1'b1;
                    if (p2_found_reg)
                    begin
                        res_idx                  = 5'(p2_idx_reg);
                        res_claim                = now_reg;
                        res_name                 = tag_reg;
                        in_use_next[p2_idx_reg]  = 1'b1;
                        is_idle_next[p2_idx_reg] = 1'b0;
                        wr_sum_en                = 1'b1;
                        wr_sum_data              = '0;
                        wr_claim_en              = 1'b1;
                    end
                    else
                    begin
                        res_status = sita_pkg::ST_FULL;
                        res_idx    = '0;
                    end
                end
                sita_pkg::OP_RELEASE:
                begin
                    res_emit = 1'b1;
                    if (!in_range)
                    begin
                        res_status = sita_pkg::ST_NOT_CLAIMED;
                    end
                    else
                    begin
                        if (p2_inuse_reg)
                        begin
                            res_claim = p2_claim_reg;
                            res_name  = p2_name_reg;
                        end
                        in_use_next[p2_idx_reg] = 1'b0;
                    end
                end
                sita_pkg::OP_MARK_IDLE,
                sita_pkg::OP_MARK_BUSY:
                begin
                    res_emit = 1'b1;
                    if (!in_range || !p2_inuse_reg)
                    begin
                        res_status = sita_pkg::ST_NOT_CLAIMED;
                    end
                    else
                    begin
                        res_claim = p2_claim_reg;
                        res_name  = p2_name_reg;
                        if (op_reg == sita_pkg::OP_MARK_IDLE)
                        begin
                            if (now_reg == '0)
                            begin
                                res_status = sita_pkg::ST_ZERO_TIME;
                            end
                            else if (!p2_idle_reg)
                            begin
                                is_idle_next[p2_idx_reg] = 1'b1;
                                wr_start_en              = 1'b1;
                            end
                        end
                        else if (p2_idle_reg)
                        begin
                            is_idle_next[p2_idx_reg] = 1'b0;
                            wr_sum_en                = 1'b1;
                        end
                    end
                end
                sita_pkg::OP_SNAPSHOT:
                begin
                    res_emit = 1'b1;
                    if (p2_found_reg)
                    begin
                        res_idx   = 5'(p2_idx_reg);
                        res_total = total_sum;
                        res_claim = p2_claim_reg;
                        res_name  = p2_name_reg;
                        res_last  = p2_last_reg;
                    end
                    else
                    begin
                        res_status = sita_pkg::ST_EMPTY;
                        res_idx    = '0;
                    end
                end
                default:
                begin
                    res_emit = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_start_en)
        begin
            idle_start_mem[p2_idx_reg] <= now_reg;
        end
        if (wr_sum_en)
        begin
            idle_sum_mem[p2_idx_reg] <= wr_sum_data;
        end
        if (wr_claim_en)
        begin
            claim_time_mem[p2_idx_reg] <= now_reg;
            name_mem[p2_idx_reg]       <= tag_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_emit)
        begin
            status_reg     <= res_status;
            slot_index_reg <= res_idx;
            idle_total_reg <= res_total;
            claimed_at_reg <= res_claim;
            slot_name_reg  <= res_name;
            last_reg       <= res_last;
        end
    end

    assign done       = done_reg;
    assign status     = status_reg;
    assign slot_index = slot_index_reg;
    assign idle_total = idle_total_reg;
    assign claimed_at = claimed_at_reg;
    assign slot_name  = slot_name_reg;
    assign last       = last_reg;

endmodule

`default_nettype wire

/* rtl/slot_idle_time_accounting.sv */
// top level of the slot idle-time accounting table
//
//  channel   handshake           payload
//  command   start, busy         op, slot, now, name_tag
//  result    done (strobe)       status, slot_index, idle_total, claimed_at, slot_name, last
//
// a command is taken when start is high and busy is low; busy then stays high through span
// and apply for table ops; no new command is taken until busy drops
// a snapshot first reads its claimed slots (at least 1), one slot read per cycle
// the first result passes the read, span and result registers; the rest follow back to back
// reset clears the claimed and idle flags at once; slot memories are not cleared
// results are not stalled: done is high for exactly one cycle per result
`default_nettype none

module slot_idle_time_accounting #(
    parameter int SLOT_COUNT = 32
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [2:0]  op,
    input  wire logic [4:0]  slot,
    input  wire logic [63:0] now,
    input  wire logic [55:0] name_tag,
    output logic             done,
    output logic [2:0]       status,
    output logic [4:0]       slot_index,
    output logic [63:0]      idle_total,
    output logic [63:0]      claimed_at,
    output logic [55:0]      slot_name,
    output logic             last
);

    sita_pkg::ctrl_cmd_t  cmd;
    sita_pkg::dp_status_t dp_status;

    sita_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .dp_status (dp_status),
        .cmd       (cmd)
    );

    sita_datapath #(
        .SLOT_COUNT (SLOT_COUNT)
    ) u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .dp_status  (dp_status),
        .op         (op),
        .slot       (slot),
        .now        (now),
        .name_tag   (name_tag),
        .done       (done),
        .status     (status),
        .slot_index (slot_index),
        .idle_total (idle_total),
        .claimed_at (claimed_at),
        .slot_name  (slot_name),
        .last       (last)
    );

endmodule

`default_nettype wire

/* rtl/sita_checker.sv */
// port-level checker for the idle-time table and its bind to the top level
`default_nettype none

module sita_checker (
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       start,
    input wire logic       busy,
    input wire logic [2:0] op,
    input wire logic       done,
    input wire logic [2:0] status,
    input wire logic       last
);

    logic accept;
    logic table_op;

    assign accept   = start && !busy;
    assign table_op = (op == sita_pkg::OP_CLAIM) || (op == sita_pkg::OP_RELEASE)
                   || (op == sita_pkg::OP_MARK_IDLE) || (op == sita_pkg::OP_MARK_BUSY);

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> busy)
        else $error("busy not raised after transaction");

    a_table_op_result: assert property (@(posedge clk) disable iff (!rst_n)
        accept && table_op |-> ##3 (done && last))
        else $error("table op result missing or late");

    a_snapshot_burst: assert property (@(posedge clk) disable iff (!rst_n)
        done && !last |=> done)
        else $error("gap inside snapshot burst");

    a_error_single: assert property (@(posedge clk) disable iff (!rst_n)
        done && (status != sita_pkg::ST_OK) |-> last)
        else $error("error result not final");

    a_last_frees: assert property (@(posedge clk) disable iff (!rst_n)
        done && last |-> !busy)
        else $error("still busy on final result");

endmodule

bind slot_idle_time_accounting sita_checker u_sita_checker (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .op     (op),
    .done   (done),
    .status (status),
    .last   (last)
);

`default_nettype wire
